### design/sqwt_pkg.sv
// Shared types and constants for the shell quoted word tokenizer.
`timescale 1ns / 1ps
`default_nettype none
package sqwt_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;
    localparam int QUEUE_CW    = QUEUE_AW + 1;

    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_BSL   = 8'h5c;
    localparam logic [7:0] CH_SQ    = 8'h27;
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef enum logic [2:0] {
        K_BYTE = 3'd0,
        K_EOW  = 3'd1,
        K_EOL  = 3'd2,
        K_EOI  = 3'd3,
        K_ERR  = 3'd4
    } kind_t;

    typedef struct packed {
        logic        pair;
        kind_t       kind0;
        logic [7:0]  byte0;
        logic [15:0] len0;
        kind_t       kind1;
        logic [7:0]  byte1;
        logic [15:0] line;
    } cmd_t;

endpackage
`default_nettype wire

### design/sqwt_front.sv
// Front end: accepts input beats, runs the tokenizer state and issues result commands.
`timescale 1ns / 1ps
`default_nettype none
module sqwt_front
    import sqwt_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic       in_kind,
    input  wire logic [7:0] in_byte,
    input  wire logic       q_full,
    output logic            push,
    output cmd_t            cmd
);

    typedef enum logic [1:0] {
        PH_BETWEEN = 2'd0,
        PH_COMMENT = 2'd1,
        PH_WORD    = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        QM_NONE   = 2'd0,
        QM_SINGLE = 2'd1,
        QM_DOUBLE = 2'd2
    } quote_t;

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        return (v == 16'hffff) ? v : v + 16'd1;
    endfunction

    phase_t      phase_reg, phase_next;
    quote_t      qm_reg, qm_next;
    logic        esc_reg, esc_next;
    logic        ws_reg, ws_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] line_reg, line_next;

    logic        accept;
    logic [1:0]  n_res;
    kind_t       k0, k1;
    logic [7:0]  b0, b1;
    logic [15:0] l0;

    quote_t      wqm;
    logic        wesc, wws;
    logic [15:0] wlen;
    logic        is_lf, is_blank, is_q, do_word, keep;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        phase_next = phase_reg;
        qm_next    = qm_reg;
        esc_next   = esc_reg;
        ws_next    = ws_reg;
        len_next   = len_reg;
        line_next  = line_reg;
        n_res      = 2'd0;
        k0         = K_BYTE;
        k1         = K_BYTE;
        b0         = 8'd0;
        b1         = 8'd0;
        l0         = 16'd0;
        is_lf      = (in_byte == CH_LF);
        is_blank   = (in_byte == CH_SPACE) || (in_byte == CH_TAB) || (in_byte == CH_CR);
        do_word    = 1'b0;
        keep       = 1'b0;
        wqm        = (phase_reg == PH_WORD) ? qm_reg : QM_NONE;
        wesc       = (phase_reg == PH_WORD) ? esc_reg : 1'b0;
        wws        = (phase_reg == PH_WORD) ? ws_reg : 1'b0;
        wlen       = (phase_reg == PH_WORD) ? len_reg : 16'd0;
        is_q       = ((wqm == QM_SINGLE) && (in_byte == CH_SQ))
                  || ((wqm == QM_DOUBLE) && (in_byte == CH_DQ));

        if (in_kind)
        begin
            if ((phase_reg == PH_WORD) && (esc_reg || (qm_reg != QM_NONE)))
            begin
                n_res = 2'd1;
                k0    = K_ERR;
            end
            else if ((phase_reg == PH_WORD) && ws_reg)
            begin
                n_res = 2'd2;
                k0    = K_EOW;
                l0    = len_reg;
                k1    = K_EOI;
            end
            else
            begin
                n_res = 2'd1;
                k0    = K_EOI;
            end
            phase_next = PH_BETWEEN;
            qm_next    = QM_NONE;
            esc_next   = 1'b0;
            ws_next    = 1'b0;
            len_next   = 16'd0;
        end
        else
        begin
            if (is_lf)
                line_next = line_reg + 16'd1;
            if (phase_reg != PH_WORD)
            begin
                if (is_lf)
                begin
                    phase_next = PH_BETWEEN;
                    n_res      = 2'd1;
                    k0         = K_EOL;
                end
                else if ((phase_reg == PH_COMMENT) || is_blank)
                begin
                    phase_next = phase_reg;
                end
                else if (in_byte == CH_HASH)
                begin
                    phase_next = PH_COMMENT;
                end
                else
                begin
                    do_word = 1'b1;
                end
            end
            else
            begin
                do_word = 1'b1;
            end

            if (do_word)
            begin
                phase_next = PH_WORD;
                qm_next    = wqm;
                esc_next   = wesc;
                ws_next    = wws;
                len_next   = wlen;
                if (!wesc && (wqm == QM_NONE) && (is_blank || is_lf))
                begin
                    phase_next = PH_BETWEEN;
                    qm_next    = QM_NONE;
                    esc_next   = 1'b0;
                    ws_next    = 1'b0;
                    len_next   = 16'd0;
                    if (wws)
                    begin
                        k0 = K_EOW;
                        l0 = wlen;
                        if (is_lf)
                        begin
                            n_res = 2'd2;
                            k1    = K_EOL;
                        end
                        else
                        begin
                            n_res = 2'd1;
                        end
                    end
                    else if (is_lf)
                    begin
                        n_res = 2'd1;
                        k0    = K_EOL;
                    end
                end
                else if ((in_byte == CH_BSL) && !wesc && (wqm != QM_SINGLE))
                begin
                    esc_next = 1'b1;
                end
                else if (((in_byte == CH_SQ) || (in_byte == CH_DQ)) && (wqm == QM_NONE)
                         && !wesc)
                begin
                    qm_next = (in_byte == CH_SQ) ? QM_SINGLE : QM_DOUBLE;
                    ws_next = 1'b1;
                end
                else if (is_q && !wesc)
                begin
                    qm_next = QM_NONE;
                end
                else if (is_lf && wesc && (wqm != QM_SINGLE))
                begin
                    esc_next = 1'b0;
                end
                else
                begin
                    keep = wesc && (wqm != QM_NONE) && (in_byte != CH_BSL) && !is_q;
                    if (keep)
                    begin
                        n_res    = 2'd2;
                        b0       = CH_BSL;
                        b1       = in_byte;
                        len_next = sat_inc(sat_inc(wlen));
                    end
                    else
                    begin
                        n_res    = 2'd1;
                        b0       = in_byte;
                        len_next = sat_inc(wlen);
                    end
                    ws_next  = 1'b1;
                    esc_next = 1'b0;
                end
            end
        end
    end

    assign push      = accept && (n_res != 2'd0);
    assign cmd.pair  = (n_res == 2'd2);
    assign cmd.kind0 = k0;
    assign cmd.byte0 = b0;
    assign cmd.len0  = l0;
    assign cmd.kind1 = k1;
    assign cmd.byte1 = b1;
    assign cmd.line  = line_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_BETWEEN;
            qm_reg    <= QM_NONE;
            esc_reg   <= 1'b0;
            ws_reg    <= 1'b0;
            len_reg   <= 16'd0;
            line_reg  <= 16'd1;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            qm_reg    <= qm_next;
            esc_reg   <= esc_next;
            ws_reg    <= ws_next;
            len_reg   <= len_next;
            line_reg  <= line_next;
        end
    end

endmodule
`default_nettype wire

### design/sqwt_queue.sv
// Command queue between the front end and the output stage.
`timescale 1ns / 1ps
`default_nettype none
module sqwt_queue
    import sqwt_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire cmd_t  push_cmd,
    output logic       full,
    output logic       head_valid,
    output cmd_t       head_cmd,
    input  wire logic  pop,
    output logic [QUEUE_CW-1:0] count
);

    cmd_t                mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_CW-1:0] count_reg, count_next;
    logic                do_push, do_pop;

    assign full       = (count_reg == QUEUE_CW'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = mem_reg[rd_ptr_reg];
    assign count      = count_reg;
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + QUEUE_CW'(1);
        else if (!do_push && do_pop)
            count_next = count_reg - QUEUE_CW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + QUEUE_AW'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + QUEUE_AW'(1);
            count_reg <= count_next;
        end
    end

endmodule
`default_nettype wire

### design/sqwt_back.sv
// Output stage: expands queued commands into result beats in an output register.
`timescale 1ns / 1ps
`default_nettype none
module sqwt_back
    import sqwt_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        head_valid,
    input  wire cmd_t        head_cmd,
    output logic             pop,
    output logic             out_valid,
    input  wire logic        out_ready,
    output kind_t            out_kind,
    output logic [7:0]       out_byte,
    output logic [15:0]      word_len,
    output logic [15:0]      line_number,
    output logic             out_last
);

    logic        valid_reg;
    logic        second_reg;
    kind_t       kind_reg;
    logic [7:0]  byte_reg;
    logic [15:0] len_reg;
    logic [15:0] line_reg;
    logic        last_reg;
    logic        load;

    assign load = !valid_reg || out_ready;
    assign pop  = load && head_valid && (!head_cmd.pair || second_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            second_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= head_valid;
            if (head_valid)
                second_reg <= head_cmd.pair && !second_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && head_valid)
        begin
            line_reg <= head_cmd.line;
            if (second_reg)
            begin
                kind_reg <= head_cmd.kind1;
                byte_reg <= head_cmd.byte1;
                len_reg  <= 16'd0;
                last_reg <= 1'b1;
            end
            else
            begin
                kind_reg <= head_cmd.kind0;
                byte_reg <= head_cmd.byte0;
                len_reg  <= head_cmd.len0;
                last_reg <= !head_cmd.pair;
            end
        end
    end

    assign out_valid   = valid_reg;
    assign out_kind    = kind_reg;
    assign out_byte    = byte_reg;
    assign word_len    = len_reg;
    assign line_number = line_reg;
    assign out_last    = last_reg;

endmodule
`default_nettype wire

### design/shell_quoted_word_tokenizer_top.sv
// Top level of the shell quoted word tokenizer: front end, command queue, output stage.
// An accepted beat's results go into the command queue, then into the output register.
// Throughput: one input beat per cycle while the queue has room; the output sends one result
// beat per cycle while ready, two beats for a two-result item; a 4-entry queue absorbs bursts.
// Input is stalled only while the command queue is full.
// Reset: asynchronous, clears tokenizer state and queue; line count restarts at one.
`timescale 1ns / 1ps
`default_nettype none
module shell_quoted_word_tokenizer_top
    import sqwt_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // in_byte[7:0]
    input  wire logic [0:0]  s_axis_tuser,   // kind[0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // out_byte[7:0], word_len[23:8],
                                             // line_number[39:24]
    output logic [2:0]       m_axis_tuser,   // out_kind[2:0]
    output logic             m_axis_tlast
);

    logic                push, q_full, head_valid, pop;
    cmd_t                push_cmd, head_cmd;
    logic [QUEUE_CW-1:0] q_count;
    kind_t               out_kind;
    logic [7:0]          out_byte;
    logic [15:0]         word_len, line_number;

    sqwt_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_kind  (s_axis_tuser[0]),
        .in_byte  (s_axis_tdata),
        .q_full   (q_full),
        .push     (push),
        .cmd      (push_cmd)
    );

    sqwt_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .count      (q_count)
    );

    sqwt_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head_cmd    (head_cmd),
        .pop         (pop),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_kind    (out_kind),
        .out_byte    (out_byte),
        .word_len    (word_len),
        .line_number (line_number),
        .out_last    (m_axis_tlast)
    );

    assign m_axis_tdata = {line_number, word_len, out_byte};
    assign m_axis_tuser = out_kind;

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= QUEUE_CW'(QUEUE_DEPTH))
        else $error("command queue count beyond depth");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !s_axis_tready)
        else $error("input taken while queue full");

    a_len_only_eow: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (out_kind != K_EOW) |-> (word_len == 16'd0))
        else $error("word length on a non end-of-word beat");

    a_byte_only_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (out_kind != K_BYTE) |-> (out_byte == 8'd0))
        else $error("byte on a non data beat");

    a_pair_tail: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
        else $error("second result of an item not presented next");

endmodule
`default_nettype wire
